### src/djs_pkg.sv
// ----------------------------------------------------------------------------
// djs_pkg
// Shared types and constants of the deadline job sequencer: payload structs,
// controller/datapath command and status groups, and store sizing.
// ----------------------------------------------------------------------------
package djs_pkg;

    // Store sizing
    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    // Field widths
    localparam int ID_W     = 8;
    localparam int DL_W     = 8;
    localparam int PROFIT_W = 32;
    localparam int SLOT_W   = 6;
    localparam int JOB_W    = PROFIT_W + DL_W + ID_W;

    typedef struct packed {
        logic [ID_W-1:0]     job_id;
        logic [DL_W-1:0]     deadline;
        logic [PROFIT_W-1:0] profit;
        logic                last_job;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0]     out_job_id;
        logic [SLOT_W-1:0]   slot_index;
        logic [PROFIT_W-1:0] out_profit;
        logic                run_last;
        logic                none_scheduled;
    } out_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_job;     // store accepted job if room
        logic clear_run;    // clear slot map, flags and counters of a run
        logic scan_cmp;     // compare fetched job with current best, advance scan
        logic place_load;   // load search start, mark best job as used
        logic search_step;  // test one slot, take it or step down
        logic next_rank;    // advance to next profit rank
        logic addr_out;     // store read address comes from slot owner
        logic out_skip;     // advance output slot index
        logic out_put;      // load result for current slot
        logic out_none;     // load the nothing-scheduled result
        logic finish;       // empty the store
    } djs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last;    // scan index at last stored job
        logic rank_last;    // rank at last stored job
        logic search_done;  // search reached slot zero or found a free slot
        logic slot_taken;   // current output slot holds a job
        logic emit_last;    // current result is the final one of the run
        logic sched_none;   // no job got a slot
        logic out_free;     // output register can take a result
    } djs_status_t;

endpackage

### src/deadline_job_sequencer.sv
// ----------------------------------------------------------------------------
// deadline_job_sequencer
// Greedy job sequencing with deadlines: loads jobs, schedules each by
// descending profit into the latest free slot before its deadline, and
// streams the scheduled jobs out in slot order.
// ----------------------------------------------------------------------------
// Jobs are taken one per cycle while the block is loading; up to MAX_JOBS (16)
// are stored and further ones are ignored. A job with last_job set starts the
// run, and s_ready stays low until the last result of that run has been
// loaded into the output register; that result may still be waiting on
// m_ready when loading resumes. For each profit rank the run rescans the job
// store through its registered read port, reading and then comparing each
// entry, then searches down from the lower of the best job's deadline and
// the job count for a free slot. The output phase walks the slots in order,
// loads each taken slot's job, waiting on m_ready for a pending result. A run
// that places no job yields one result with none_scheduled and run_last set.
module deadline_job_sequencer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  djs_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output djs_pkg::out_t m_payload
);
    import djs_pkg::*;

    djs_cmd_t    cmd;
    djs_status_t st;

    djs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .last_job (s_payload.last_job),
        .s_ready  (s_ready),
        .st       (st),
        .cmd      (cmd)
    );

    djs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

### src/djs_ram.sv
// ----------------------------------------------------------------------------
// djs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module djs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/djs_ctrl.sv
// ----------------------------------------------------------------------------
// djs_ctrl
// Controller of the deadline job sequencer: loads jobs, runs the profit
// selection, slot search and output phases by commanding the datapath.
// ----------------------------------------------------------------------------
module djs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                last_job,
    output logic                s_ready,
    input  djs_pkg::djs_status_t st,
    output djs_pkg::djs_cmd_t   cmd
);
    import djs_pkg::*;

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_CMP = 3'd2;
    localparam logic [2:0] ST_PLACE    = 3'd3;
    localparam logic [2:0] ST_SEARCH   = 3'd4;
    localparam logic [2:0] ST_OUT_CHK  = 3'd5;
    localparam logic [2:0] ST_OUT_PUT  = 3'd6;
    localparam logic [2:0] ST_OUT_NONE = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_LOAD);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cmd.load_job = 1'b1;
                    if (last_job) begin
                        cmd.clear_run = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                cmd.scan_cmp = 1'b1;
                state_next   = st.scan_last ? ST_PLACE : ST_SCAN_RD;
            end
            ST_PLACE: begin
                cmd.place_load = 1'b1;
                state_next     = ST_SEARCH;
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (st.search_done) begin
                    if (st.rank_last) begin
                        state_next = ST_OUT_CHK;
                    end else begin
                        cmd.next_rank = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end
                end
            end
            ST_OUT_CHK: begin
                cmd.addr_out = 1'b1;
                if (st.sched_none) begin
                    state_next = ST_OUT_NONE;
                end else if (st.slot_taken) begin
                    state_next = ST_OUT_PUT;
                end else begin
                    cmd.out_skip = 1'b1;
                end
            end
            ST_OUT_PUT: begin
                cmd.addr_out = 1'b1;
                if (st.out_free) begin
                    cmd.out_put = 1'b1;
                    if (st.emit_last) begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_OUT_CHK;
                    end
                end
            end
            ST_OUT_NONE: begin
                if (st.out_free) begin
                    cmd.out_none = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

### src/djs_datapath.sv
// ----------------------------------------------------------------------------
// djs_datapath
// Datapath of the deadline job sequencer: job store, best-profit scan,
// slot map with owners, downward slot search and the output register.
// ----------------------------------------------------------------------------
module djs_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  djs_pkg::in_t        s_payload,
    input  djs_pkg::djs_cmd_t   cmd,
    output djs_pkg::djs_status_t st,
    output logic                m_valid,
    input  logic                m_ready,
    output djs_pkg::out_t       m_payload
);
    import djs_pkg::*;

    // Counters and scan state
    logic [CNT_W-1:0]    job_count_reg,  job_count_next;
    logic [CNT_W-1:0]    sched_cnt_reg,  sched_cnt_next;
    logic [CNT_W-1:0]    emit_cnt_reg,   emit_cnt_next;
    logic [IDX_W-1:0]    scan_idx_reg,   scan_idx_next;
    logic [IDX_W-1:0]    rank_reg,       rank_next;
    logic [IDX_W-1:0]    out_idx_reg,    out_idx_next;
    logic [CNT_W-1:0]    top_reg,        top_next;
    logic                best_found_reg, best_found_next;
    logic [IDX_W-1:0]    best_idx_reg,   best_idx_next;
    logic [PROFIT_W-1:0] best_profit_reg, best_profit_next;
    logic [DL_W-1:0]     best_dl_reg,    best_dl_next;
    logic [MAX_JOBS-1:0] used_reg,       used_next;
    logic [MAX_JOBS-1:0] taken_reg,      taken_next;
    logic [IDX_W-1:0]    owner_reg [MAX_JOBS];
    logic                m_valid_reg,    m_valid_next;
    out_t                m_payload_reg,  m_payload_next;

    // Store signals
    logic                store_full;
    logic                store_we;
    logic [IDX_W-1:0]    store_raddr;
    logic [JOB_W-1:0]    store_rdata;
    logic [ID_W-1:0]     rd_id;
    logic [DL_W-1:0]     rd_dl;
    logic [PROFIT_W-1:0] rd_profit;
    logic                better;
    logic [IDX_W-1:0]    probe_idx;
    logic                top_zero;
    logic                probe_free;
    logic [CNT_W-1:0]    top_start;

    assign store_full  = (job_count_reg == CNT_W'(MAX_JOBS));
    assign store_we    = cmd.load_job && !store_full;
    assign store_raddr = cmd.addr_out ? owner_reg[out_idx_reg] : scan_idx_reg;
    assign {rd_profit, rd_dl, rd_id} = store_rdata;

    djs_ram #(
        .WIDTH (JOB_W),
        .DEPTH (MAX_JOBS)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (job_count_reg[IDX_W-1:0]),
        .wdata ({s_payload.profit, s_payload.deadline, s_payload.job_id}),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Selection, search and output decode
    assign better     = !used_reg[scan_idx_reg] && (!best_found_reg || rd_profit > best_profit_reg);
    assign top_zero   = (top_reg == '0);
    assign probe_idx  = IDX_W'(top_reg - CNT_W'(1));
    assign probe_free = !taken_reg[probe_idx];
    assign top_start  = (DL_W'(job_count_reg) < best_dl_reg) ? job_count_reg
                                                             : CNT_W'(best_dl_reg);

    assign st.scan_last   = (CNT_W'(scan_idx_reg) + CNT_W'(1) == job_count_reg);
    assign st.rank_last   = (CNT_W'(rank_reg) + CNT_W'(1) == job_count_reg);
    assign st.search_done = top_zero || probe_free;
    assign st.slot_taken  = taken_reg[out_idx_reg];
    assign st.emit_last   = (emit_cnt_reg + CNT_W'(1) == sched_cnt_reg);
    assign st.sched_none  = (sched_cnt_reg == '0);
    assign st.out_free    = !m_valid_reg || m_ready;

    // Next-state logic
    always_comb begin
        job_count_next   = job_count_reg;
        sched_cnt_next   = sched_cnt_reg;
        emit_cnt_next    = emit_cnt_reg;
        scan_idx_next    = scan_idx_reg;
        rank_next        = rank_reg;
        out_idx_next     = out_idx_reg;
        top_next         = top_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_profit_next = best_profit_reg;
        best_dl_next     = best_dl_reg;
        used_next        = used_reg;
        taken_next       = taken_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_payload_next   = m_payload_reg;

        // Load a job into the store
        if (store_we) begin
            job_count_next = job_count_reg + CNT_W'(1);
        end

        // Start a run
        if (cmd.clear_run) begin
            sched_cnt_next  = '0;
            emit_cnt_next   = '0;
            scan_idx_next   = '0;
            rank_next       = '0;
            out_idx_next    = '0;
            best_found_next = 1'b0;
            used_next       = '0;
            taken_next      = '0;
        end

        // Keep the highest unused profit; strict compare keeps load order on ties
        if (cmd.scan_cmp) begin
            if (better) begin
                best_found_next  = 1'b1;
                best_idx_next    = scan_idx_reg;
                best_profit_next = rd_profit;
                best_dl_next     = rd_dl;
            end
            scan_idx_next = st.scan_last ? '0 : scan_idx_reg + IDX_W'(1);
        end

        if (cmd.place_load) begin
            top_next               = top_start;
            used_next[best_idx_reg] = 1'b1;
        end

        // Take the probed slot if free, otherwise step down
        if (cmd.search_step && !top_zero) begin
            if (probe_free) begin
                taken_next[probe_idx] = 1'b1;
                sched_cnt_next        = sched_cnt_reg + CNT_W'(1);
            end else begin
                top_next = top_reg - CNT_W'(1);
            end
        end

        if (cmd.next_rank) begin
            rank_next       = rank_reg + IDX_W'(1);
            best_found_next = 1'b0;
        end

        if (cmd.out_skip) begin
            out_idx_next = out_idx_reg + IDX_W'(1);
        end

        // Load a result for the current slot
        if (cmd.out_put) begin
            m_valid_next                  = 1'b1;
            m_payload_next.out_job_id     = rd_id;
            m_payload_next.slot_index     = SLOT_W'(out_idx_reg);
            m_payload_next.out_profit     = rd_profit;
            m_payload_next.run_last       = st.emit_last;
            m_payload_next.none_scheduled = 1'b0;
            out_idx_next                  = out_idx_reg + IDX_W'(1);
            emit_cnt_next                 = emit_cnt_reg + CNT_W'(1);
        end

        if (cmd.out_none) begin
            m_valid_next                  = 1'b1;
            m_payload_next                = '0;
            m_payload_next.run_last       = 1'b1;
            m_payload_next.none_scheduled = 1'b1;
        end

        if (cmd.finish) begin
            job_count_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_count_reg  <= '0;
            sched_cnt_reg  <= '0;
            emit_cnt_reg   <= '0;
            scan_idx_reg   <= '0;
            rank_reg       <= '0;
            out_idx_reg    <= '0;
            top_reg        <= '0;
            best_found_reg <= 1'b0;
            used_reg       <= '0;
            taken_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            job_count_reg  <= job_count_next;
            sched_cnt_reg  <= sched_cnt_next;
            emit_cnt_reg   <= emit_cnt_next;
            scan_idx_reg   <= scan_idx_next;
            rank_reg       <= rank_next;
            out_idx_reg    <= out_idx_next;
            top_reg        <= top_next;
            best_found_reg <= best_found_next;
            used_reg       <= used_next;
            taken_reg      <= taken_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        best_idx_reg    <= best_idx_next;
        best_profit_reg <= best_profit_next;
        best_dl_reg     <= best_dl_next;
        m_payload_reg   <= m_payload_next;
        if (cmd.search_step && !top_zero && probe_free) begin
            owner_reg[probe_idx] <= best_idx_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        job_count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count beyond store depth");

    a_taken_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(taken_reg) == 32'(sched_cnt_reg))
        else $error("slot map and scheduled count disagree");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_cnt_reg <= sched_cnt_reg)
        else $error("more results than scheduled jobs");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_put || cmd.out_none) |-> st.out_free)
        else $error("result loaded over a pending result");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for deadline_job_sequencer. Job sets are streamed in
// with random gaps, including empty-deadline jobs, tied profits, deadlines
// past the set size and sets that overflow the store. An in-bench scheduler
// predicts each run's slot list, and every result transfer is compared
// field by field against it, while the result side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import djs_pkg::*;

    // Greedy deadline scheduler and store of the slot results still due
    class job_board;
        in_t  loaded_jobs[$];
        out_t due_slots[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Store a transferred job; a last_job mark runs the schedule
        function void note_job(in_t job);
            if (loaded_jobs.size() < MAX_JOBS) begin
                loaded_jobs.insert(loaded_jobs.size(), job);
            end
            if (job.last_job) begin
                schedule_set();
            end
        endfunction

        function void schedule_set();
            int   rank[$];
            bit   taken[MAX_JOBS];
            int   owner[MAX_JOBS];
            int   count;
            int   pos;
            int   top;
            int   placed;
            out_t res;
            count = loaded_jobs.size();
            placed = 0;
            // order by profit, highest first; ties keep load order
            for (int i = 0; i < count; i++) begin
                pos = rank.size();
                for (int p = 0; p < rank.size(); p++) begin
                    if (loaded_jobs[rank[p]].profit < loaded_jobs[i].profit) begin
                        pos = p;
                        break;
                    end
                end
                rank.insert(pos, i);
            end
            // take the latest free slot below min(count, deadline)
            for (int i = 0; i < MAX_JOBS; i++) begin
                taken[i] = 1'b0;
                owner[i] = 0;
            end
            for (int i = 0; i < count; i++) begin
                top = loaded_jobs[rank[i]].deadline;
                if (top > count) begin
                    top = count;
                end
                while (top > 0) begin
                    top--;
                    if (!taken[top]) begin
                        taken[top] = 1'b1;
                        owner[top] = rank[i];
                        break;
                    end
                end
            end
            // emit in slot order; mark the final one
            for (int i = 0; i < count; i++) begin
                if (taken[i]) begin
                    res = '0;
                    res.out_job_id = loaded_jobs[owner[i]].job_id;
                    res.slot_index = i[SLOT_W-1:0];
                    res.out_profit = loaded_jobs[owner[i]].profit;
                    due_slots.insert(due_slots.size(), res);
                    placed++;
                end
            end
            if (placed == 0) begin
                res = '0;
                res.run_last = 1'b1;
                res.none_scheduled = 1'b1;
                due_slots.insert(due_slots.size(), res);
            end else begin
                due_slots[due_slots.size() - 1].run_last = 1'b1;
            end
            loaded_jobs.delete();
        endfunction

        // Compare one result transfer against the oldest slot due
        function void check_result(out_t got);
            out_t want;
            if (due_slots.size() == 0) begin
                $error("unexpected result: id %0d slot %0d profit %0d",
                       got.out_job_id, got.slot_index, got.out_profit);
                mismatches++;
                return;
            end
            want = due_slots.pop_front();
            if (got.out_job_id !== want.out_job_id) begin
                $error("out_job_id: expected %0d, actual %0d",
                       want.out_job_id, got.out_job_id);
                mismatches++;
            end
            if (got.slot_index !== want.slot_index) begin
                $error("slot_index: expected %0d, actual %0d",
                       want.slot_index, got.slot_index);
                mismatches++;
            end
            if (got.out_profit !== want.out_profit) begin
                $error("out_profit: expected %0d, actual %0d",
                       want.out_profit, got.out_profit);
                mismatches++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0d, actual %0d",
                       want.run_last, got.run_last);
                mismatches++;
            end
            if (got.none_scheduled !== want.none_scheduled) begin
                $error("none_scheduled: expected %0d, actual %0d",
                       want.none_scheduled, got.none_scheduled);
                mismatches++;
            end
        endfunction

        function int waiting();
            return due_slots.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;

    job_board board = new();
    bit       quiet_tail = 1'b0;
    int       jobs_sent = 0;

    deadline_job_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Observe transfers on both channels
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_job(s_payload);
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_payload);
        end
    end

    // Result side: stall in random bursts, none in the tail
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Offer one job and hold it until the transfer
    task automatic send_job(input logic [ID_W-1:0] id, input logic [DL_W-1:0] dl,
                            input logic [PROFIT_W-1:0] profit, input logic last);
        in_t job;
        job.job_id   = id;
        job.deadline = dl;
        job.profit   = profit;
        job.last_job = last;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= job;
        do @(posedge aclk); while (!s_ready);
        jobs_sent++;
    endtask

    initial begin
        int set_size;
        int pick;
        int dl_top;
        logic [PROFIT_W-1:0] profit;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lone job with deadline zero: nothing scheduled
        send_job(8'h00, 8'd0, 32'h0000_0000, 1'b1);
        // lone job at the field extremes
        send_job(8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        // tied profits, deadlines past the set size and zero
        send_job(8'h11, 8'd2, 32'd500, 1'b0);
        send_job(8'h22, 8'd255, 32'd500, 1'b0);
        send_job(8'h33, 8'd0, 32'd900, 1'b0);
        send_job(8'h44, 8'd1, 32'd500, 1'b1);
        // overfill the store; the mark on an ignored job still starts the run
        for (int i = 0; i < MAX_JOBS + 2; i++) begin
            send_job(8'(8'hA0 + i), 8'(i % 5), 32'(i * 7 % 4),
                     i == MAX_JOBS + 1);
        end

        // random job sets: mostly small, some full, a few overflowing
        while (jobs_sent < 210) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                set_size = $urandom_range(1, 5);
            end else if (pick < 8) begin
                set_size = $urandom_range(6, 12);
            end else if (pick == 8) begin
                set_size = MAX_JOBS;
            end else begin
                set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
            end
            if (jobs_sent >= 170) begin
                quiet_tail = 1'b1;
            end
            dl_top = (set_size < MAX_JOBS ? set_size : MAX_JOBS) + 1;
            for (int i = 0; i < set_size; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    profit = $urandom_range(0, 3);
                end else begin
                    profit = $urandom;
                end
                send_job(ID_W'($urandom_range(0, 255)),
                         ($urandom_range(0, 3) == 0) ? DL_W'($urandom_range(0, 255))
                                                     : DL_W'($urandom_range(0, dl_top)),
                         profit, i == set_size - 1);
            end
        end
        s_valid <= 1'b0;

        // let the monitor take the final job, drain the last run, then idle
        @(posedge aclk);
        while (board.waiting() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
